/* rtl/four_level_page_table_walker_macros.svh */
// Assertion macros for the page table walker checker.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// same-cycle implication
`define PTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ptw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the table slot function of the page table walker.
// No dependencies.
package ptw_pkg;

	localparam int TABLE_FRAMES = 16;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_BITS = 9;
	localparam int STORE_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
	localparam int FRAME_BITS = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
	localparam int SLOT_BITS = FRAME_BITS + IDX_BITS;

	localparam int PFN_BITS = 40;
	localparam int PADDR_BITS = 52;
	localparam int VADDR_BITS = 48;
	localparam int ENTRY_BITS = 64;
	localparam int ENTRY_INDEX_BITS = 13;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_WRITABLE = 1;
	localparam int BIT_USER = 2;
	localparam int BIT_HUGE = 7;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_LOOKUP,
		KIND_UNMAP,
		KIND_RSVD
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_ROOT_ZERO,
		ST_NOT_PRESENT,
		ST_HUGE,
		ST_USER,
		ST_WRITE,
		ST_OUTSIDE,
		ST_BAD_ADDR
	} status_t;

	typedef struct packed {
		logic                 clear;
		logic                 accept;
		logic                 first;
		logic [1:0]           level;
		logic                 advance;
		logic                 commit;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic clear_last;
	} dp_status_t;

	typedef struct packed {
		logic                 ok;
		logic [SLOT_BITS-1:0] slot;
	} slot_res_t;

	function automatic slot_res_t slot_of(input logic [PFN_BITS-1:0] frame,
			input logic [IDX_BITS-1:0] idx, input logic [PFN_BITS-1:0] base);
		slot_res_t r;
		logic [PFN_BITS-1:0] rel;
		rel = frame - base;
		r.ok = (frame >= base) && (rel < PFN_BITS'(TABLE_FRAMES));
		r.slot = {rel[FRAME_BITS-1:0], idx};
		return r;
	endfunction

endpackage

/* rtl/ptw_ctrl.sv */
`timescale 1ns / 1ps
// Walk controller: sequences clearing, prechecks, level reads and result commit.
// Depends on ptw_pkg.
module ptw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ptw_pkg::dp_status_t st,
	output ptw_pkg::cmd_t     cmd
);
	import ptw_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_WALK
	} state_t;

	state_t     state_q;
	logic [1:0] level_q;
	logic       out_valid_q;
	logic       busy;
	logic       out_free;

	assign busy = (state_q == S_START) || (state_q == S_WALK);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.clear = (state_q == S_CLEAR);
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.first = (state_q == S_START);
		cmd.level = level_q;
		cmd.advance = busy && !st.done;
		cmd.commit = busy && st.done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			level_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (st.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.accept) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end else if (cmd.advance) begin
						level_q <= 2'd0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end else if (cmd.advance) begin
						level_q <= level_q + 2'd1;
					end
				end
			endcase
		end
	end

endmodule

/* rtl/ptw_datapath.sv */
`timescale 1ns / 1ps
// Walker datapath: item registers, table store, entry checks and result registers.
// Depends on ptw_pkg.
module ptw_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ptw_pkg::cmd_t                       cmd,
	output ptw_pkg::dp_status_t                 st,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptw_pkg::PFN_BITS-1:0]        cfg_data,
	input  logic [1:0]                          kind,
	input  logic [ptw_pkg::PADDR_BITS-1:0]      root_address,
	input  logic [ptw_pkg::VADDR_BITS-1:0]      virt_addr,
	input  logic                                need_user,
	input  logic                                need_writable,
	input  logic [ptw_pkg::ENTRY_INDEX_BITS-1:0] entry_index,
	input  logic [ptw_pkg::ENTRY_BITS-1:0]      entry_value,
	output logic [2:0]                          status,
	output logic [ptw_pkg::ENTRY_BITS-1:0]      leaf_entry,
	output logic [ptw_pkg::PADDR_BITS-1:0]      phys_addr
);
	import ptw_pkg::*;

	logic [ENTRY_BITS-1:0] mem [STORE_DEPTH];

	logic [PFN_BITS-1:0]         base_q;
	logic [SLOT_BITS-1:0]        clr_q;
	kind_t                       kind_q;
	logic [PADDR_BITS-1:0]       root_q;
	logic [VADDR_BITS-1:0]       va_q;
	logic                        need_user_q;
	logic                        need_writable_q;
	logic [ENTRY_INDEX_BITS-1:0] entry_index_q;
	logic [ENTRY_BITS-1:0]       entry_value_q;
	logic [ENTRY_BITS-1:0]       rdata_q;
	logic [SLOT_BITS-1:0]        slot_q;
	status_t                     status_q;
	logic [ENTRY_BITS-1:0]       leaf_q;
	logic [PADDR_BITS-1:0]       paddr_q;

	logic                  done;
	status_t               ev_status;
	logic                  leaf_hit;
	slot_res_t             sr;
	logic [IDX_BITS-1:0]   idx_next;
	logic                  user_eff;
	logic                  in_range;
	logic                  we;
	logic [SLOT_BITS-1:0]  waddr;
	logic [ENTRY_BITS-1:0] wdata;

	assign cfg_ready = 1'b1;
	assign user_eff = need_user_q && (kind_q == KIND_LOOKUP);
	assign in_range = 32'(entry_index_q) < 32'(STORE_DEPTH);

	always_comb begin
		unique case (cmd.level)
			2'd0: idx_next = va_q[38:30];
			2'd1: idx_next = va_q[29:21];
			2'd2: idx_next = va_q[20:12];
			default: idx_next = '0;
		endcase
	end

	always_comb begin
		done = 1'b1;
		ev_status = ST_OK;
		leaf_hit = 1'b0;
		sr = '0;
		if (cmd.first) begin
			sr = slot_of(root_q[51:12], va_q[47:39], base_q);
			priority if (kind_q == KIND_WRITE) begin
				ev_status = ST_OK;
			end else if (kind_q == KIND_RSVD) begin
				ev_status = ST_BAD_ADDR;
			end else if (root_q[51:12] == '0) begin
				ev_status = ST_ROOT_ZERO;
			end else if (user_eff && ((va_q == '0) || va_q[47])) begin
				ev_status = ST_BAD_ADDR;
			end else if ((kind_q == KIND_UNMAP) && (va_q[11:0] != '0)) begin
				ev_status = ST_BAD_ADDR;
			end else if (!sr.ok) begin
				ev_status = ST_OUTSIDE;
			end else begin
				done = 1'b0;
			end
		end else begin
			sr = slot_of(rdata_q[51:12], idx_next, base_q);
			priority if (!rdata_q[BIT_PRESENT]) begin
				ev_status = ST_NOT_PRESENT;
			end else if (((cmd.level == 2'd1) || (cmd.level == 2'd2)) && rdata_q[BIT_HUGE]) begin
				ev_status = ST_HUGE;
			end else if (user_eff && !rdata_q[BIT_USER]) begin
				ev_status = ST_USER;
			end else if (cmd.level == 2'd3) begin
				if ((kind_q == KIND_LOOKUP) && need_writable_q && !rdata_q[BIT_WRITABLE]) begin
					ev_status = ST_WRITE;
				end else begin
					ev_status = ST_OK;
					leaf_hit = 1'b1;
				end
			end else if (!sr.ok) begin
				ev_status = ST_OUTSIDE;
			end else begin
				done = 1'b0;
			end
		end
	end

	assign st.done = done;
	assign st.clear_last = (clr_q == SLOT_BITS'(STORE_DEPTH - 1));

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.commit && (kind_q == KIND_WRITE) && cmd.first) begin
			we = in_range;
			waddr = SLOT_BITS'(entry_index_q);
			wdata = entry_value_q;
		end else if (cmd.commit && (kind_q == KIND_UNMAP) && leaf_hit) begin
			we = 1'b1;
			waddr = slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.advance) begin
			rdata_q <= mem[sr.slot];
			slot_q <= sr.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			clr_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind_t'(kind);
			root_q <= root_address;
			va_q <= virt_addr;
			need_user_q <= need_user;
			need_writable_q <= need_writable;
			entry_index_q <= entry_index;
			entry_value_q <= entry_value;
		end
		if (cmd.commit) begin
			status_q <= ev_status;
			if (leaf_hit) begin
				leaf_q <= rdata_q;
				paddr_q <= {rdata_q[51:12], va_q[11:0]};
			end else begin
				leaf_q <= '0;
				paddr_q <= '0;
			end
		end
	end

	assign status = status_q;
	assign leaf_entry = leaf_q;
	assign phys_addr = paddr_q;

endmodule

/* rtl/four_level_page_table_walker.sv */
`timescale 1ns / 1ps
// Four-level page table walker over a window of table frames held on chip.
// Depends on ptw_pkg, ptw_ctrl and ptw_datapath.
//
// After reset the table store (STORE_DEPTH = TABLE_FRAMES * 512 entries, 8192
// by default) is cleared one entry per cycle, and in_stall stays high until the
// last entry is cleared; configuration writes are taken throughout. One item is
// in flight at a time. An entry write or an item rejected before the walk
// commits its result from the start state, after which the walker returns to
// idle for the next item. A walk issues one read per level from the single
// read port of the table store, each level decided from the registered read
// data, so a full walk passes through the start state and each walk level in
// turn before its commit; a walk that fails early is shorter. An unmap clears
// the leaf in the commit cycle through the write port. A finished result waits
// in the output register while out_stall is high; the next item may be
// accepted meanwhile, and its commit waits until the register is free.
module four_level_page_table_walker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ptw_pkg::PFN_BITS-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [ptw_pkg::PADDR_BITS-1:0]       root_address,
	input  logic [ptw_pkg::VADDR_BITS-1:0]       virt_addr,
	input  logic                                 need_user,
	input  logic                                 need_writable,
	input  logic [ptw_pkg::ENTRY_INDEX_BITS-1:0] entry_index,
	input  logic [ptw_pkg::ENTRY_BITS-1:0]       entry_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           status,
	output logic [ptw_pkg::ENTRY_BITS-1:0]       leaf_entry,
	output logic [ptw_pkg::PADDR_BITS-1:0]       phys_addr
);
	import ptw_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ptw_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.root_address  (root_address),
		.virt_addr     (virt_addr),
		.need_user     (need_user),
		.need_writable (need_writable),
		.entry_index   (entry_index),
		.entry_value   (entry_value),
		.status        (status),
		.leaf_entry    (leaf_entry),
		.phys_addr     (phys_addr)
	);

endmodule

/* rtl/ptw_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker_macros.svh.
`include "four_level_page_table_walker_macros.svh"

module ptw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     status,
	input logic [ptw_pkg::ENTRY_BITS-1:0] leaf_entry,
	input logic [ptw_pkg::PADDR_BITS-1:0] phys_addr
);
	import ptw_pkg::*;

	`PTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled item dropped")
	`PTW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"second item taken while a walk is open")
	`PTW_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK),
		(leaf_entry == '0) && (phys_addr == '0), "failed item carries data")
	`PTW_ASSERT_NOW(a_frame_match, out_valid && (status == ST_OK) && (leaf_entry != '0),
		phys_addr[51:12] == leaf_entry[51:12], "address frame differs from leaf")

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.leaf_entry (leaf_entry),
	.phys_addr  (phys_addr)
);
